>>> rtl/hkrd_pkg.sv
package hkrd_pkg;

  localparam int unsigned KEY_SLOTS = 6;
  localparam int unsigned KEY_W     = 8;
  localparam int unsigned MOD_W     = 8;

  localparam logic [KEY_W-1:0] CAPS_LOCK_CODE = 8'h39;
  localparam logic [KEY_W-1:0] NUM_LOCK_CODE  = 8'h53;

  // event slots: modifier, one press per slot, one release per slot, clear
  localparam int unsigned NUM_EV  = 2 * KEY_SLOTS + 2;
  localparam int unsigned EV_MOD  = 0;
  localparam int unsigned EV_PRS  = 1;
  localparam int unsigned EV_REL  = KEY_SLOTS + 1;
  localparam int unsigned EV_CLR  = 2 * KEY_SLOTS + 1;

  localparam int unsigned IN_W    = MOD_W + KEY_SLOTS * KEY_W;
  localparam int unsigned IN_TW   = ((IN_W + 7) / 8) * 8;
  localparam int unsigned OUT_W   = KEY_W + MOD_W + 3;
  localparam int unsigned OUT_TW  = ((OUT_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    EVK_MODIFIER = 2'd0,
    EVK_PRESS    = 2'd1,
    EVK_RELEASE  = 2'd2,
    EVK_CLEAR    = 2'd3
  } ev_kind_e;

  typedef logic [KEY_SLOTS-1:0][KEY_W-1:0] keys_t;

  typedef struct packed {
    keys_t            keys;
    logic [MOD_W-1:0] mods;
  } report_t;

  // everything the emitter needs to walk one report's events
  typedef struct packed {
    logic [NUM_EV-1:0] mask;
    keys_t             cur;
    keys_t             prev;
    logic [MOD_W-1:0]  mods;
    logic              caps;
    logic              num;
    logic              led;
  } evt_t;

endpackage

>>> rtl/hkrd_diff.sv
module hkrd_diff import hkrd_pkg::*; (
  input  report_t rpt_i,
  input  keys_t   prev_i,
  input  logic    caps_i,
  input  logic    num_i,
  output evt_t    evt_o
);

  logic [KEY_SLOTS-1:0] cur_act, prev_act, in_prev, in_cur;
  logic [KEY_SLOTS-1:0] new_key, caps_hit, num_hit, press, gone;
  logic                 caps_tog, num_tog;

  always_comb begin
    logic run_c;
    logic run_p;
    run_c = 1'b1;
    run_p = 1'b1;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      // scans stop at the first empty slot
      run_c      = run_c & (rpt_i.keys[i] != '0);
      run_p      = run_p & (prev_i[i] != '0);
      cur_act[i] = run_c;
      prev_act[i] = run_p;
      in_prev[i] = 1'b0;
      in_cur[i]  = 1'b0;
      for (int k = 0; k < KEY_SLOTS; k++) begin
        in_prev[i] = in_prev[i] | (prev_i[k] == rpt_i.keys[i]);
        in_cur[i]  = in_cur[i]  | (rpt_i.keys[k] == prev_i[i]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < KEY_SLOTS; i++) begin
      new_key[i]  = cur_act[i] & ~in_prev[i];
      caps_hit[i] = new_key[i] & (rpt_i.keys[i] == CAPS_LOCK_CODE);
      num_hit[i]  = new_key[i] & (rpt_i.keys[i] == NUM_LOCK_CODE);
      press[i]    = new_key[i] & ~caps_hit[i] & ~num_hit[i];
      gone[i]     = prev_act[i] & ~in_cur[i];
    end
  end

  // repeated new lock codes toggle once per slot
  assign caps_tog = ^caps_hit;
  assign num_tog  = ^num_hit;

  always_comb begin
    evt_o                                 = '0;
    evt_o.mask[EV_MOD]                    = 1'b1;
    evt_o.mask[EV_PRS +: KEY_SLOTS]       = press;
    evt_o.mask[EV_REL +: KEY_SLOTS]       = gone;
    evt_o.mask[EV_CLR]                    = (rpt_i.mods == '0) && (rpt_i.keys[0] == '0);
    evt_o.cur                             = rpt_i.keys;
    evt_o.prev                            = prev_i;
    evt_o.mods                            = rpt_i.mods;
    evt_o.caps                            = caps_i ^ caps_tog;
    evt_o.num                             = num_i ^ num_tog;
    evt_o.led                             = (|caps_hit) | (|num_hit);
  end

endmodule

>>> rtl/hkrd_emit.sv
module hkrd_emit import hkrd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              ld_i,
  input  evt_t              evt_i,
  output logic              ev_ready_o,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [OUT_TW-1:0] m_axis_tdata_o,  // key_code, modifier_state, caps, num, led
  output logic [1:0]        m_axis_tuser_o,  // event_kind
  output logic              m_axis_tlast_o
);

  logic [NUM_EV-1:0] mask_q, mask_d, pick, rest;
  evt_t              hold_q;
  logic              pop;
  logic              out_vld_q;
  ev_kind_e          kind;
  logic [KEY_W-1:0]  code;
  logic [OUT_TW-1:0] data_q;
  logic [1:0]        user_q;
  logic              last_q;

  // lowest pending event
  assign pick = mask_q & (~mask_q + 1'b1);
  assign rest = mask_q & ~pick;
  assign pop  = (mask_q != '0) && (!out_vld_q || m_axis_tready_i);

  assign ev_ready_o = (mask_q == '0) || (pop && (rest == '0));

  always_comb begin
    code = '0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      code = code | ({KEY_W{pick[EV_PRS + i]}} & hold_q.cur[i])
                  | ({KEY_W{pick[EV_REL + i]}} & hold_q.prev[i]);
    end
    if (pick[EV_MOD]) begin
      kind = EVK_MODIFIER;
    end else if (|pick[EV_PRS +: KEY_SLOTS]) begin
      kind = EVK_PRESS;
    end else if (|pick[EV_REL +: KEY_SLOTS]) begin
      kind = EVK_RELEASE;
    end else begin
      kind = EVK_CLEAR;
    end
  end

  always_comb begin
    mask_d = mask_q;
    if (ld_i) begin
      mask_d = evt_i.mask;
    end else if (pop) begin
      mask_d = rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      mask_q <= mask_d;
      if (pop) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      hold_q <= evt_i;
    end
    if (pop) begin
      data_q <= OUT_TW'({hold_q.led, hold_q.num, hold_q.caps, hold_q.mods, code});
      user_q <= kind;
      last_q <= (rest == '0);
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = data_q;
  assign m_axis_tuser_o  = user_q;
  assign m_axis_tlast_o  = last_q;

`ifndef ASSERT_OFF
  a_ld_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_i |-> ev_ready_o)
    else $error("report loaded while events pending");
  a_ld_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_i |=> mask_q[EV_MOD])
    else $error("report loaded without modifier event");
  a_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(pick))
    else $error("more than one event picked");
  a_mod_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && pick[EV_MOD]) |=> (m_axis_tdata_o[KEY_W-1:0] == '0))
    else $error("modifier event carries a key code");
`endif

endmodule

>>> rtl/hid_keyboard_report_diff.sv
// Channel  Dir  Signals                 Contents (lowest bit up)
// s_axis   in   tvalid/tready/tdata     modifier_bits, key_slot_0 .. key_slot_5
// m_axis   out  tvalid/tready/tdata     key_code, modifier_state, caps_lock_on,
//                                       num_lock_on, led_update, zero pad
//               tuser                   event_kind
//               tlast                   last_event
//
// A request is registered in the input register, then its diff is loaded
// into the event buffer once the buffer drains; the buffer sends one event
// per cycle while m_axis_tready allows, 1 to 2*KEY_SLOTS+1 events per report.
// The next request is taken while the previous one's last event leaves.
// Reset clears valids, previous keys and both lock states.
// A low m_axis_tready holds the output; the input register then fills and
// s_axis_tready drops.
module hid_keyboard_report_diff import hkrd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [IN_TW-1:0]  s_axis_tdata_i,   // modifier_bits, key_slot_0..5
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [OUT_TW-1:0] m_axis_tdata_o,   // key_code, modifier_state, caps, num, led
  output logic [1:0]        m_axis_tuser_o,   // event_kind
  output logic              m_axis_tlast_o
);

  // input register
  logic    in_vld_q;
  report_t rpt_q;

  // state carried from report to report
  keys_t   prev_q;
  logic    caps_q;
  logic    num_q;

  evt_t    evt;
  logic    ev_ready;
  logic    ld;

  // diff moves into the event buffer once its previous events are drained
  assign ld              = in_vld_q && ev_ready;
  assign s_axis_tready_o = !in_vld_q || ld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      prev_q   <= '0;
      caps_q   <= 1'b0;
      num_q    <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        in_vld_q <= 1'b1;
      end else if (ld) begin
        in_vld_q <= 1'b0;
      end
      if (ld) begin
        prev_q <= rpt_q.keys;   // full copy, empty slots included
        caps_q <= evt.caps;
        num_q  <= evt.num;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      rpt_q <= report_t'(s_axis_tdata_i[IN_W-1:0]);
    end
  end

  hkrd_diff u_diff (
    .rpt_i  (rpt_q),
    .prev_i (prev_q),
    .caps_i (caps_q),
    .num_i  (num_q),
    .evt_o  (evt)
  );

  hkrd_emit u_emit (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ld_i            (ld),
    .evt_i           (evt),
    .ev_ready_o      (ev_ready),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

>>> verif/testbench.sv
module testbench;
  import hkrd_pkg::*;

  // Longest correct run is roughly 280 reports * 13 events * the longest
  // receiver stall, plus sender gaps; this limit leaves a wide margin.
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned RANDOM_REPORTS = 260;

  // One decoded keyboard event as it leaves m_axis.
  typedef struct packed {
    ev_kind_e         kind;
    logic [KEY_W-1:0] code;
    logic [MOD_W-1:0] mods;
    logic             caps;
    logic             num;
    logic             led;
    logic             last;
  } key_event_t;

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [IN_TW-1:0]  s_axis_tdata_i = '0;   // modifier_bits, key_slot_0 .. key_slot_5
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b0;
  logic [OUT_TW-1:0] m_axis_tdata_o;        // key_code, modifier_state, caps, num, led, pad
  logic [1:0]        m_axis_tuser_o;        // event_kind
  logic              m_axis_tlast_o;        // last_event

  hid_keyboard_report_diff uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // ---------------------------------------------------------------------
  // Shadow of the decoder: last report's key slots and the two lock states
  // ---------------------------------------------------------------------
  keys_t            prev_keys = '0;
  logic             caps_state = 1'b0;
  logic             num_state = 1'b0;

  logic [IN_TW-1:0] report_queue[$];    // reports waiting for the driver
  key_event_t       expected_events[$]; // events still owed by the block

  int unsigned reports_issued = 0;
  int unsigned reports_taken = 0;
  int unsigned events_seen = 0;
  int unsigned led_reports = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  function automatic bit holds_code(keys_t list, logic [KEY_W-1:0] code);
    for (int k = 0; k < KEY_SLOTS; k++) begin
      if (list[k] == code) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Diff one accepted report against the stored one and queue its events.
  task automatic diff_report(input logic [IN_TW-1:0] word);
    report_t          rep;
    key_event_t       evs[$];
    key_event_t       ev;
    logic             led;
    logic             is_new;
    logic [KEY_W-1:0] c;
    rep = report_t'(word[IN_W-1:0]);
    led = 1'b0;
    ev = '0;
    ev.kind = EVK_MODIFIER;
    evs.push_back(ev);
    // press scan stops at the first empty slot; lock keys toggle on a new press only
    for (int i = 0; i < KEY_SLOTS; i++) begin
      c = rep.keys[i];
      if (c == '0) break;
      is_new = !holds_code(prev_keys, c);
      if (c == CAPS_LOCK_CODE) begin
        if (is_new) begin
          caps_state = ~caps_state;
          led = 1'b1;
        end
      end else if (c == NUM_LOCK_CODE) begin
        if (is_new) begin
          num_state = ~num_state;
          led = 1'b1;
        end
      end else if (is_new) begin
        ev.kind = EVK_PRESS;
        ev.code = c;
        evs.push_back(ev);
      end
    end
    // release scan over the old slots, again up to the first empty one
    for (int i = 0; i < KEY_SLOTS; i++) begin
      c = prev_keys[i];
      if (c == '0) break;
      if (!holds_code(rep.keys, c)) begin
        ev.kind = EVK_RELEASE;
        ev.code = c;
        evs.push_back(ev);
      end
    end
    if (rep.mods == '0 && rep.keys[0] == '0) begin
      ev.kind = EVK_CLEAR;
      ev.code = '0;
      evs.push_back(ev);
    end
    prev_keys = rep.keys;   // full copy, slots after a hole included
    if (led) led_reports++;
    foreach (evs[i]) begin
      ev = evs[i];
      ev.mods = rep.mods;
      ev.caps = caps_state;
      ev.num  = num_state;
      ev.led  = led;
      ev.last = (i == evs.size() - 1);
      expected_events.push_back(ev);
    end
  endtask

  task automatic queue_report(input logic [MOD_W-1:0] mods,
                              input logic [KEY_W-1:0] s0, s1, s2, s3, s4, s5);
    report_t rep;
    rep.mods = mods;
    rep.keys[0] = s0;
    rep.keys[1] = s1;
    rep.keys[2] = s2;
    rep.keys[3] = s3;
    rep.keys[4] = s4;
    rep.keys[5] = s5;
    report_queue.push_back(IN_TW'(rep));
  endtask

  // Mostly a small pool of letters so codes collide across reports,
  // with the two lock keys and now and then any nonzero code.
  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return CAPS_LOCK_CODE;
    if (r == 1) return NUM_LOCK_CODE;
    if (r == 2) return KEY_W'($urandom_range(1, 255));
    return KEY_W'($urandom_range(8'h04, 8'h0F));
  endfunction

  // ---------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Driver: bursts of requests with random idle gaps, changes at negedge
  // ---------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned idle_left = 0;

  always @(negedge clk_i) begin
    // a held request stays put until the monitor has seen it taken
    if (rst_ni && (!s_axis_tvalid_i || reports_taken == reports_issued)) begin
      if (idle_left > 0) begin
        idle_left--;
        s_axis_tvalid_i <= 1'b0;
      end else if (report_queue.size() > 0) begin
        s_axis_tdata_i  <= report_queue.pop_front();
        s_axis_tvalid_i <= 1'b1;
        reports_issued++;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 11);
          idle_left  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: switches among always-ready, coin-flip, periodic and
  // occasional long stalls
  // ---------------------------------------------------------------------
  int unsigned rx_phase = 0;
  int unsigned rx_mode = 0;
  int unsigned stall_left = 0;

  always @(negedge clk_i) begin
    rx_phase++;
    if (rx_phase % 48 == 0) rx_mode = $urandom_range(0, 3);
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      case (rx_mode)
        0: m_axis_tready_i <= 1'b1;
        1: m_axis_tready_i <= 1'($urandom_range(0, 1));
        2: m_axis_tready_i <= (rx_phase % 3) != 0;
        default: begin
          m_axis_tready_i <= 1'b1;
          if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(4, 20);
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: predict on each taken request, check each taken event
  // ---------------------------------------------------------------------
  key_event_t got_ev;
  key_event_t want_ev;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        diff_report(s_axis_tdata_i);
        reports_taken++;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        events_seen++;
        got_ev.kind = ev_kind_e'(m_axis_tuser_o);
        got_ev.code = m_axis_tdata_o[KEY_W-1:0];
        got_ev.mods = m_axis_tdata_o[KEY_W +: MOD_W];
        got_ev.caps = m_axis_tdata_o[KEY_W + MOD_W];
        got_ev.num  = m_axis_tdata_o[KEY_W + MOD_W + 1];
        got_ev.led  = m_axis_tdata_o[KEY_W + MOD_W + 2];
        got_ev.last = m_axis_tlast_o;
        if (expected_events.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected event: kind=%0d code=%h mods=%h caps=%b num=%b led=%b last=%b",
                     got_ev.kind, got_ev.code, got_ev.mods, got_ev.caps, got_ev.num,
                     got_ev.led, got_ev.last);
        end else begin
          want_ev = expected_events.pop_front();
          if (got_ev !== want_ev) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("event mismatch after report %0d:", reports_taken);
              $display("  expected kind=%0d code=%h mods=%h caps=%b num=%b led=%b last=%b",
                       want_ev.kind, want_ev.code, want_ev.mods, want_ev.caps,
                       want_ev.num, want_ev.led, want_ev.last);
              $display("  actual   kind=%0d code=%h mods=%h caps=%b num=%b led=%b last=%b",
                       got_ev.kind, got_ev.code, got_ev.mods, got_ev.caps,
                       got_ev.num, got_ev.led, got_ev.last);
            end
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout: %0d of %0d reports taken, %0d events outstanding",
               reports_taken, reports_issued, expected_events.size());
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------
  initial begin
    logic [KEY_W-1:0] held[KEY_SLOTS];
    logic [KEY_W-1:0] slot[KEY_SLOTS];
    logic [MOD_W-1:0] mods;
    int unsigned      held_n;
    int unsigned      kept;
    int unsigned      adds;
    int unsigned      r;
    int unsigned      total;

    // directed: empty report, full rollover, lock keys, holes, repeats, clear
    queue_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_report(8'hFF, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09);
    queue_report(8'h00, 8'hFF, 8'hFE, 8'h80, 8'h01, 8'h7F, 8'hAA);  // 6 new, 6 gone
    queue_report(8'h01, CAPS_LOCK_CODE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_report(8'h02, CAPS_LOCK_CODE, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00); // caps held
    queue_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);  // caps released
    queue_report(8'h00, CAPS_LOCK_CODE, CAPS_LOCK_CODE, NUM_LOCK_CODE,
                 8'h00, 8'h00, 8'h00);                               // caps toggles twice
    queue_report(8'h10, 8'h04, 8'h00, 8'h05, 8'h00, 8'h00, 8'h00);  // hole stops press scan
    queue_report(8'h10, 8'h05, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00);  // 05 was stored
    queue_report(8'h00, 8'h0A, 8'h0A, 8'h00, 8'h00, 8'h00, 8'h00);  // same code twice
    queue_report(8'h00, 8'h00, 8'h22, 8'h00, 8'h00, 8'h00, 8'h00);  // clear, 22 stored
    queue_report(8'h00, 8'h22, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);  // release scan stops
    queue_report(8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);  // modifiers block clear
    queue_report(8'h00, NUM_LOCK_CODE, 8'h00, 8'h00, 8'h00, 8'h00, NUM_LOCK_CODE);
    queue_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_report(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    queue_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_report(8'hAA, 8'h55, 8'h2A, CAPS_LOCK_CODE, NUM_LOCK_CODE, 8'h11, 8'h01);
    queue_report(8'h55, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);

    // random: mostly keys going down and up like a real keyboard,
    // the rest holes, duplicates and raw noise
    held_n = 0;
    for (int n = 0; n < RANDOM_REPORTS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        held_n = 0;
      end else begin
        kept = 0;
        for (int i = 0; i < held_n; i++) begin
          if ($urandom_range(0, 3) != 0) begin
            held[kept] = held[i];
            kept++;
          end
        end
        held_n = kept;
        adds = $urandom_range(0, 2);
        for (int i = 0; i < adds; i++) begin
          if (held_n < KEY_SLOTS) begin
            held[held_n] = pick_key();
            held_n++;
          end
        end
      end
      for (int i = 0; i < KEY_SLOTS; i++) slot[i] = (i < held_n) ? held[i] : 8'h00;
      case ($urandom_range(0, 3))
        0:       mods = MOD_W'($urandom_range(0, 255));
        1:       mods = MOD_W'(1 << $urandom_range(0, MOD_W - 1));
        default: mods = '0;
      endcase
      if (r >= 75 && r < 85) begin
        // broken sequence: punch a hole or copy one slot onto another
        if ($urandom_range(0, 1) == 0) slot[$urandom_range(0, KEY_SLOTS - 2)] = 8'h00;
        else slot[$urandom_range(0, KEY_SLOTS - 1)] = slot[$urandom_range(0, KEY_SLOTS - 1)];
      end else if (r >= 85) begin
        for (int i = 0; i < KEY_SLOTS; i++) slot[i] = KEY_W'($urandom_range(0, 255));
        mods = MOD_W'($urandom_range(0, 255));
      end
      queue_report(mods, slot[0], slot[1], slot[2], slot[3], slot[4], slot[5]);
    end
    total = report_queue.size();

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (reports_taken < total) @(posedge clk_i);
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (expected_events.size() != 0) begin
      mismatches++;
      $display("%0d expected events never arrived", expected_events.size());
    end
    $display("Decoded %0d reports into %0d events; %0d reports toggled a lock.",
             reports_taken, events_seen, led_reports);
    $display("Sender bursts and receiver stalls were randomized; %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
